>>> rtl/core/bpfa_pkg.sv
package bpfa_pkg;

	// Sizing of the page store.
	localparam int MAX_PAGE_COUNT = 16384;
	localparam int PAGE_BYTES     = 4096;
	localparam int WORD_BITS      = 32;
	localparam int WORD_COUNT     = (MAX_PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;

	localparam int ADDR_W     = 32;
	localparam int CFG_W      = 15;
	localparam int CNT_W      = $clog2(MAX_PAGE_COUNT + 1);
	localparam int PAGE_W     = $clog2(MAX_PAGE_COUNT);
	localparam int WADDR_W    = $clog2(WORD_COUNT);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int FULL_W     = CNT_W - BIT_W;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

	// Register reset values.
	localparam int TOTAL_RESET    = 16384;
	localparam int RESERVED_FLOOR = 256;

	// Configuration port.
	localparam int CFG_ADDR_W = 3;
	localparam int PDATA_W    = 32;
	localparam logic REG_TOTAL    = 1'b0;
	localparam logic REG_RESERVED = 1'b1;

	typedef enum logic [1:0] {
		KIND_INIT  = 2'd0,
		KIND_ALLOC = 2'd1,
		KIND_FREE  = 2'd2,
		KIND_QUERY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_OOM     = 2'd1,
		ST_IGNORED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_INIT,
		S_SCAN,
		S_LOOK,
		S_CHECK,
		S_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    take;
		logic    sweep_wr;
		logic    sweep_res;
		logic    init_fin;
		logic    scan_clr;
		logic    scan_rd;
		logic    alloc_wr;
		logic    look_rd;
		logic    free_wr;
		logic    stage;
		status_t stage_status;
		logic    stage_alloc;
		logic    stage_used;
		logic    out_load;
	} bpfa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		kind_t kind;
		logic  sweep_last;
		logic  scan_none;
		logic  scan_hit;
		logic  scan_end;
		logic  free_ok;
		logic  query_ok;
		logic  out_busy;
	} bpfa_stat_t;

endpackage

>>> rtl/core/bpfa_ram.sv
module bpfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/bpfa_dp.sv
module bpfa_dp
	import bpfa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  bpfa_cmd_t         cmd,
	output bpfa_stat_t        stat,
	input  logic [1:0]        kind,
	input  logic [ADDR_W-1:0] address,
	input  logic [CNT_W-1:0]  tot_lim,
	input  logic [CNT_W-1:0]  res_lim,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] page_address,
	output logic [1:0]        status,
	output logic              page_used,
	output logic [CNT_W-1:0]  free_pages
);

	// Bits of a word that lie below the page limit.
	function automatic logic [WORD_BITS-1:0] below_mask(input logic [WADDR_W-1:0] w,
		input logic [CNT_W-1:0] lim);
		logic [FULL_W-1:0]    full;
		logic [BIT_W-1:0]     rem;
		logic [WORD_BITS-1:0] m;
		full = lim[CNT_W-1:BIT_W];
		rem  = lim[BIT_W-1:0];
		if (FULL_W'(w) < full) begin
			m = '1;
		end else if (FULL_W'(w) == full) begin
			m = (WORD_BITS'(1) << rem) - WORD_BITS'(1);
		end else begin
			m = '0;
		end
		return m;
	endfunction

	kind_t              kind_q;
	logic [PAGE_W-1:0]  page_q;
	logic               page_hi_q;
	logic               addr_zero_q;
	logic [WADDR_W-1:0] sweep_q;
	logic [FULL_W-1:0]  hint_q;
	logic [FULL_W-1:0]  scan_addr_q;
	logic [WADDR_W-1:0] chk_addr_q;
	logic               chk_vld_q;
	logic [CNT_W-1:0]   used_q;
	logic [ADDR_W-1:0]  rs_addr_q;
	status_t            rs_status_q;
	logic               rs_used_q;
	logic               out_valid_q;
	logic [ADDR_W-1:0]  page_address_q;
	status_t            status_q;
	logic               page_used_q;
	logic [CNT_W-1:0]   free_pages_q;

	logic                 ram_we;
	logic [WADDR_W-1:0]   ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [WADDR_W-1:0]   ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic [CNT_W-1:0]     tot_m1;
	logic [FULL_W-1:0]    tot_last;
	logic                 tot_zero;
	logic                 scan_issue;
	logic [WORD_BITS-1:0] cand;
	logic                 found;
	logic [BIT_W-1:0]     ffz;
	logic [ADDR_W-1:0]    found_addr;
	logic                 look_bit;
	logic [WADDR_W-1:0]   page_word;
	logic [CNT_W-1:0]     free_now;

	assign tot_zero   = (tot_lim == '0);
	assign tot_m1     = tot_lim - CNT_W'(1);
	assign tot_last   = tot_m1[CNT_W-1:BIT_W];
	assign scan_issue = cmd.scan_rd && !tot_zero && (scan_addr_q <= tot_last);
	assign page_word  = page_q[PAGE_W-1:BIT_W];
	assign look_bit   = ram_rdata[page_q[BIT_W-1:0]];

	// Lowest free page in the word just read during a scan.
	always_comb begin
		cand = ~ram_rdata & below_mask(chk_addr_q, tot_lim);
		found = |cand;
		ffz = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				ffz = BIT_W'(i);
			end
		end
	end

	assign found_addr = ADDR_W'({chk_addr_q, ffz}) << PAGE_SHIFT;
	assign free_now   = (tot_lim > used_q) ? (tot_lim - used_q) : '0;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sweep_q;
		ram_wdata = '0;
		priority if (cmd.sweep_wr) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
			ram_wdata = cmd.sweep_res ? below_mask(sweep_q, res_lim) : '0;
		end else if (cmd.alloc_wr) begin
			ram_we    = 1'b1;
			ram_waddr = chk_addr_q;
			ram_wdata = ram_rdata | (WORD_BITS'(1) << ffz);
		end else if (cmd.free_wr) begin
			ram_we    = 1'b1;
			ram_waddr = page_word;
			ram_wdata = ram_rdata & ~(WORD_BITS'(1) << page_q[BIT_W-1:0]);
		end else begin
			ram_we    = 1'b0;
		end
	end

	assign ram_re    = scan_issue || cmd.look_rd;
	assign ram_raddr = cmd.look_rd ? page_word : scan_addr_q[WADDR_W-1:0];

	bpfa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORD_COUNT)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q      <= kind_t'(kind);
			page_q      <= address[PAGE_SHIFT+PAGE_W-1:PAGE_SHIFT];
			page_hi_q   <= |address[ADDR_W-1:PAGE_SHIFT+PAGE_W];
			addr_zero_q <= (address == '0);
		end
		if (cmd.scan_clr) begin
			scan_addr_q <= hint_q;
		end else if (cmd.scan_rd) begin
			scan_addr_q <= scan_addr_q + FULL_W'(1);
		end
		if (cmd.scan_rd) begin
			chk_addr_q <= scan_addr_q[WADDR_W-1:0];
		end
		if (cmd.stage) begin
			rs_addr_q   <= cmd.stage_alloc ? found_addr : '0;
			rs_status_q <= cmd.stage_status;
			rs_used_q   <= cmd.stage_used && look_bit;
		end
		if (cmd.out_load) begin
			page_address_q <= rs_addr_q;
			status_q       <= rs_status_q;
			page_used_q    <= rs_used_q;
			free_pages_q   <= free_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			chk_vld_q   <= 1'b0;
			hint_q      <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.sweep_wr) begin
				sweep_q <= sweep_q + WADDR_W'(1);
			end
			if (cmd.scan_clr) begin
				chk_vld_q <= 1'b0;
			end else if (cmd.scan_rd) begin
				chk_vld_q <= scan_issue;
			end
			// Every word below the hint is known to be fully used.
			if (cmd.init_fin) begin
				used_q <= res_lim;
				hint_q <= res_lim[CNT_W-1:BIT_W];
			end else if (cmd.alloc_wr) begin
				used_q <= used_q + CNT_W'(1);
				hint_q <= FULL_W'(chk_addr_q);
			end else if (cmd.free_wr) begin
				if (used_q != '0) begin
					used_q <= used_q - CNT_W'(1);
				end
				if (FULL_W'(page_word) < hint_q) begin
					hint_q <= FULL_W'(page_word);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.kind       = kind_q;
		stat.sweep_last = (sweep_q == WADDR_W'(WORD_COUNT - 1));
		stat.scan_none  = !chk_vld_q && (tot_zero || (scan_addr_q > tot_last));
		stat.scan_hit   = chk_vld_q && found;
		stat.scan_end   = chk_vld_q && !found && (FULL_W'(chk_addr_q) == tot_last);
		stat.free_ok    = !addr_zero_q && !page_hi_q && (CNT_W'(page_q) < tot_lim) && look_bit;
		stat.query_ok   = !page_hi_q;
		stat.out_busy   = out_valid_q && !out_ready;
	end

	assign out_valid    = out_valid_q;
	assign page_address = page_address_q;
	assign status       = status_q;
	assign page_used    = page_used_q;
	assign free_pages   = free_pages_q;

`ifndef SYNTHESIS
	a_used_cap: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(MAX_PAGE_COUNT))
		else $error("used page count above capacity");

	a_hint_cap: assert property (@(posedge clk) disable iff (!arst_n)
		hint_q <= FULL_W'(WORD_COUNT))
		else $error("scan hint beyond the last word");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && !out_ready))
		else $error("result loaded over an item not yet taken");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.sweep_wr, cmd.alloc_wr, cmd.free_wr}))
		else $error("more than one bitmap write source");

	a_alloc_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_wr |-> chk_vld_q && found)
		else $error("allocation written without a checked free bit");
`endif

endmodule

>>> rtl/core/bpfa_ctrl.sv
module bpfa_ctrl
	import bpfa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] kind,
	output logic       in_ready,
	input  bpfa_stat_t stat,
	output bpfa_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.sweep_wr = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					unique case (kind_t'(kind))
						KIND_INIT: state_d = S_INIT;
						KIND_ALLOC: begin
							cmd.scan_clr = 1'b1;
							state_d      = S_SCAN;
						end
						KIND_FREE, KIND_QUERY: state_d = S_LOOK;
					endcase
				end
			end
			S_INIT: begin
				cmd.sweep_wr  = 1'b1;
				cmd.sweep_res = 1'b1;
				if (stat.sweep_last) begin
					cmd.init_fin     = 1'b1;
					cmd.stage        = 1'b1;
					cmd.stage_status = ST_DONE;
					state_d          = S_RESULT;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				priority if (stat.scan_none) begin
					cmd.stage        = 1'b1;
					cmd.stage_status = ST_OOM;
					state_d          = S_RESULT;
				end else if (stat.scan_hit) begin
					cmd.alloc_wr     = 1'b1;
					cmd.stage        = 1'b1;
					cmd.stage_status = ST_DONE;
					cmd.stage_alloc  = 1'b1;
					state_d          = S_RESULT;
				end else if (stat.scan_end) begin
					cmd.stage        = 1'b1;
					cmd.stage_status = ST_OOM;
					state_d          = S_RESULT;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_LOOK: begin
				cmd.look_rd = 1'b1;
				state_d     = S_CHECK;
			end
			S_CHECK: begin
				cmd.stage = 1'b1;
				state_d   = S_RESULT;
				if (stat.kind == KIND_FREE) begin
					if (stat.free_ok) begin
						cmd.free_wr      = 1'b1;
						cmd.stage_status = ST_DONE;
					end else begin
						cmd.stage_status = ST_IGNORED;
					end
				end else if (stat.query_ok) begin
					cmd.stage_status = ST_DONE;
					cmd.stage_used   = 1'b1;
				end else begin
					cmd.stage_status = ST_IGNORED;
				end
			end
			S_RESULT: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> rtl/core/bitmap_page_frame_allocator.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_ready  kind, address
// out       output     out_valid/out_ready  page_address, status, page_used, free_pages
// cfg       input      psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// Free and query items read the page's bitmap word, check it and stage the result, which
// is loaded into the output register once that is free. An allocate item scans the bitmap
// upward from the lowest word that may hold a free page, stopping at a free one or the total.
// An init item rewrites all 512 bitmap words, one a cycle, before its result is staged.
// After reset a sweep clears all 512 bitmap words before the first item is accepted.
// While out_ready is low one result waits in the output register and the next one behind it.
module bitmap_page_frame_allocator
	import bpfa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            kind,
	input  logic [ADDR_W-1:0]     address,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ADDR_W-1:0]     page_address,
	output logic [1:0]            status,
	output logic                  page_used,
	output logic [CNT_W-1:0]      free_pages,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready
);

	// Configuration registers, both clamped to the bitmap capacity where they are used.
	// The user must see that a new value applies to the next item; no code enforces it.
	logic [CFG_W-1:0] total_q;
	logic [CFG_W-1:0] reserved_q;
	logic             reg_idx;
	logic             cfg_wr;
	logic [CNT_W-1:0] tot_lim;
	logic [CNT_W-1:0] res_lim;

	bpfa_cmd_t  cmd;
	bpfa_stat_t stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= CFG_W'(TOTAL_RESET);
			reserved_q <= CFG_W'(RESERVED_FLOOR);
		end else if (cfg_wr) begin
			if (reg_idx == REG_TOTAL) begin
				total_q <= pwdata[CFG_W-1:0];
			end else begin
				reserved_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	// Reads return the stored register value.
	assign prdata = (reg_idx == REG_TOTAL) ? PDATA_W'(total_q) : PDATA_W'(reserved_q);

	assign tot_lim = (CNT_W'(total_q) > CNT_W'(MAX_PAGE_COUNT)) ?
		CNT_W'(MAX_PAGE_COUNT) : CNT_W'(total_q);
	assign res_lim = (CNT_W'(reserved_q) > CNT_W'(MAX_PAGE_COUNT)) ?
		CNT_W'(MAX_PAGE_COUNT) : CNT_W'(reserved_q);

	// The controller sequences each item; the datapath owns the bitmap RAM,
	// the used-page count, the scan hint and the result registers.
	bpfa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.kind    (kind),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	bpfa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.kind        (kind),
		.address     (address),
		.tot_lim     (tot_lim),
		.res_lim     (res_lim),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.page_address(page_address),
		.status      (status),
		.page_used   (page_used),
		.free_pages  (free_pages)
	);

endmodule
